// File: hdl/battery_charge_termination_control_top_defines.svh
// ----------------------------------------------------------------------------
// Charge termination control: assertion macros
// Shared clocked assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_TERMINATION_CONTROL_TOP_DEFINES_SVH
`define BATTERY_CHARGE_TERMINATION_CONTROL_TOP_DEFINES_SVH

// Clocked assertion, switched off while reset is low
`define BCTC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked only on cycles with a result on the output
`define BCTC_ASSERT_OUT(label, clk, rst_n, vld, prop, msg) \
    `BCTC_ASSERT(label, clk, rst_n, (vld) |-> (prop), msg)

`endif

// File: hdl/bctc_pkg.sv
// ----------------------------------------------------------------------------
// Charge termination control package
// Shared types, mode codes and constants.
// ----------------------------------------------------------------------------
package bctc_pkg;

    localparam logic [31:0] CONTROL_PERIOD = 32'd1;
    localparam logic [31:0] START_PAUSE    = 32'd120;
    localparam logic [30:0] CAP_LIMIT_RST  = 31'd12000;
    localparam logic [30:0] CAP_LIMIT_MAX  = 31'h7FFF_FFFF;

    // Opcodes
    localparam logic OP_TICK       = 1'b0;
    localparam logic OP_PEAK_RESET = 1'b1;

    // Battery modes
    localparam logic [3:0] MODE_OTHER          = 4'd0;
    localparam logic [3:0] MODE_CHARGING       = 4'd1;
    localparam logic [3:0] MODE_CTC_CHARGING   = 4'd2;
    localparam logic [3:0] MODE_CTC_RECHARGING = 4'd3;
    localparam logic [3:0] MODE_CHARGED        = 4'd4;
    localparam logic [3:0] MODE_CTC_CHARGED    = 4'd5;
    localparam logic [3:0] MODE_CTC_RECHARGED  = 4'd6;
    localparam logic [3:0] MODE_DISCHARGING    = 4'd7;
    localparam logic [3:0] MODE_CTC_DISCHARGE  = 4'd8;
    localparam logic [3:0] MODE_CTC_DISCHARGED = 4'd9;
    localparam logic [3:0] MODE_CHARGED_OFFSET = 4'd3;

    // Charger drive
    localparam logic [1:0] DRIVE_NONE = 2'd0;
    localparam logic [1:0] DRIVE_OFF  = 2'd1;
    localparam logic [1:0] DRIVE_ON   = 2'd2;

    // Stop reasons
    localparam logic [2:0] STOP_NONE    = 3'd0;
    localparam logic [2:0] STOP_TEMP    = 3'd1;
    localparam logic [2:0] STOP_VOLTAGE = 3'd2;
    localparam logic [2:0] STOP_RISE    = 3'd3;
    localparam logic [2:0] STOP_DROP    = 3'd4;
    localparam logic [2:0] STOP_CAP     = 3'd5;

    // Register indexes
    localparam logic [2:0] REG_ON_TIME  = 3'd0;
    localparam logic [2:0] REG_OFF_TIME = 3'd1;
    localparam logic [2:0] REG_TMAX     = 3'd2;
    localparam logic [2:0] REG_FLOOR    = 3'd3;
    localparam logic [2:0] REG_VMAX     = 3'd4;
    localparam logic [2:0] REG_RISE     = 3'd5;
    localparam logic [2:0] REG_DROP     = 3'd6;
    localparam logic [2:0] REG_CUTOFF   = 3'd7;

    typedef struct packed {
        logic [15:0]        on_time;
        logic [15:0]        off_time;
        logic signed [15:0] tmax;
        logic [15:0]        v_floor;
        logic [15:0]        vmax;
        logic [15:0]        rise;
        logic [15:0]        drop;
        logic [15:0]        cutoff;
    } t_cfg;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        now_seconds;
        logic [3:0]         battery_mode;
        logic [15:0]        cell_voltage;
        logic signed [15:0] temp_oldest;
        logic signed [15:0] temp_middle;
        logic signed [15:0] temp_newest;
        logic signed [31:0] charge_pumped;
        logic [30:0]        stored_capacity;
        logic [30:0]        discharge_meter;
        logic               trickle_enable;
    } t_item;

    typedef struct packed {
        logic [31:0] last_control_time;
        logic        trickle_active;
        logic [31:0] trickle_phase_start;
        logic [15:0] voltage_peak;
        logic [30:0] capacity_limit;
    } t_state;

    typedef struct packed {
        logic        control_ran;
        logic [3:0]  new_mode;
        logic        mode_changed;
        logic [1:0]  charge_drive;
        logic [2:0]  stop_reason;
        logic        discharge_off;
        logic        reload_counter;
        logic [30:0] reload_value;
        logic        save_capacity;
        logic [30:0] saved_capacity_value;
    } t_result;

endpackage

// File: hdl/bctc_rules.sv
// ----------------------------------------------------------------------------
// Charge termination rules
// One pass of the control rules: next state and result for one item.
// ----------------------------------------------------------------------------
module bctc_rules (
    input  bctc_pkg::t_item   i_item,
    input  bctc_pkg::t_state  i_state,
    input  bctc_pkg::t_cfg    i_cfg,
    output bctc_pkg::t_state  o_state,
    output bctc_pkg::t_result o_result
);

    logic               period_done;
    logic               in_pause;
    logic               is_hot;
    logic               is_low;
    logic               is_over;
    logic               is_rising;
    logic               peak_check;
    logic [15:0]        peak_next;
    logic               is_drop;
    logic               is_full;
    logic signed [17:0] temp_span;
    logic [31:0]        trickle_elapsed;
    logic [31:0]        cap_scaled;
    logic [30:0]        cap_sat;
    logic               at_cutoff;
    logic [2:0]         reason;
    logic [3:0]         mode;

    assign mode        = i_item.battery_mode;
    assign period_done = (i_item.now_seconds - i_state.last_control_time)
                         >= bctc_pkg::CONTROL_PERIOD;

    // Stop rule chain, in priority order
    assign in_pause  = i_item.now_seconds < bctc_pkg::START_PAUSE;
    assign is_hot    = i_item.temp_newest >= i_cfg.tmax;
    assign is_low    = i_item.cell_voltage < i_cfg.v_floor;
    assign is_over   = i_item.cell_voltage > i_cfg.vmax;
    assign temp_span = 18'(i_item.temp_newest) - 18'(i_item.temp_oldest);
    assign is_rising = (i_item.temp_middle > i_item.temp_oldest)
                    && (i_item.temp_newest > i_item.temp_middle)
                    && (temp_span >= $signed({2'b00, i_cfg.rise}));
    assign peak_check = !in_pause && !is_hot && !is_low && !is_over && !is_rising;
    assign peak_next  = (i_item.cell_voltage >= i_state.voltage_peak)
                        ? i_item.cell_voltage : i_state.voltage_peak;
    assign is_drop    = (peak_next >= i_item.cell_voltage)
                     && ((peak_next - i_item.cell_voltage) >= i_cfg.drop);
    assign is_full    = i_item.charge_pumped >= $signed({1'b0, i_state.capacity_limit});

    always_comb begin
        if (in_pause) begin
            reason = bctc_pkg::STOP_NONE;
        end else if (is_hot) begin
            reason = bctc_pkg::STOP_TEMP;
        end else if (is_low) begin
            reason = bctc_pkg::STOP_NONE;
        end else if (is_over) begin
            reason = bctc_pkg::STOP_VOLTAGE;
        end else if (is_rising) begin
            reason = bctc_pkg::STOP_RISE;
        end else if (is_drop) begin
            reason = bctc_pkg::STOP_DROP;
        end else if (is_full) begin
            reason = bctc_pkg::STOP_CAP;
        end else begin
            reason = bctc_pkg::STOP_NONE;
        end
    end

    assign trickle_elapsed = i_item.now_seconds - i_state.trickle_phase_start;
    assign at_cutoff       = i_item.cell_voltage <= i_cfg.cutoff;

    // 1.5 x meter fits in 32 bits; saturate to 31
    assign cap_scaled = {1'b0, i_item.discharge_meter}
                      + {2'b00, i_item.discharge_meter[30:1]};
    assign cap_sat    = cap_scaled[31] ? bctc_pkg::CAP_LIMIT_MAX : cap_scaled[30:0];

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.new_mode = mode;

        if (i_item.opcode == bctc_pkg::OP_PEAK_RESET) begin
            o_state.voltage_peak = i_item.cell_voltage;
        end else if (period_done) begin
            o_state.last_control_time = i_item.now_seconds;
            o_result.control_ran      = 1'b1;
            case (mode)
                bctc_pkg::MODE_CHARGING, bctc_pkg::MODE_CTC_CHARGING,
                bctc_pkg::MODE_CTC_RECHARGING: begin
                    if (peak_check) begin
                        o_state.voltage_peak = peak_next;
                    end
                    o_result.stop_reason = reason;
                    if (reason != bctc_pkg::STOP_NONE) begin
                        o_result.charge_drive   = bctc_pkg::DRIVE_OFF;
                        o_result.new_mode       = mode + bctc_pkg::MODE_CHARGED_OFFSET;
                        o_result.reload_counter = 1'b1;
                        o_result.reload_value   = i_item.stored_capacity;
                    end
                end
                bctc_pkg::MODE_CHARGED, bctc_pkg::MODE_CTC_CHARGED,
                bctc_pkg::MODE_CTC_RECHARGED: begin
                    if (i_item.trickle_enable) begin
                        if (i_state.trickle_active) begin
                            if (trickle_elapsed >= {16'd0, i_cfg.on_time}) begin
                                o_state.trickle_phase_start = i_item.now_seconds;
                                o_state.trickle_active      = 1'b0;
                                o_result.charge_drive       = bctc_pkg::DRIVE_OFF;
                            end
                        end else if (trickle_elapsed >= {16'd0, i_cfg.off_time}) begin
                            o_state.trickle_phase_start = i_item.now_seconds;
                            o_state.trickle_active      = 1'b1;
                            o_result.charge_drive       = bctc_pkg::DRIVE_ON;
                        end
                    end
                end
                bctc_pkg::MODE_DISCHARGING: begin
                    o_result.discharge_off = at_cutoff;
                end
                bctc_pkg::MODE_CTC_DISCHARGE: begin
                    if (at_cutoff) begin
                        o_result.discharge_off        = 1'b1;
                        o_result.new_mode             = bctc_pkg::MODE_CTC_DISCHARGED;
                        o_result.save_capacity        = 1'b1;
                        o_result.saved_capacity_value = i_item.discharge_meter;
                        o_state.capacity_limit        = cap_sat;
                    end
                end
                default: begin
                    // other modes: nothing to do
                end
            endcase
        end
        o_result.mode_changed = o_result.new_mode != mode;
    end

endmodule

// File: hdl/battery_charge_termination_control_top.sv
// Result path: the item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the result side is ready; the rules are a single combinational pass.
// Input stays ready while a result waits, as long as the input register is free.
// Reset (synchronous, active low) restores register defaults, resets the
// controller state to its defaults and empties both stages; no clearing pass.
// ----------------------------------------------------------------------------
// Charge termination control top level
// NiMH minus delta V termination, trickle pulsing and discharge cut-off.
// ----------------------------------------------------------------------------
module battery_charge_termination_control_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic [31:0]        i_now_seconds,
    input  logic [3:0]         i_battery_mode,
    input  logic [15:0]        i_cell_voltage,
    input  logic signed [15:0] i_temp_oldest,
    input  logic signed [15:0] i_temp_middle,
    input  logic signed [15:0] i_temp_newest,
    input  logic signed [31:0] i_charge_pumped,
    input  logic [30:0]        i_stored_capacity,
    input  logic [30:0]        i_discharge_meter,
    input  logic               i_trickle_enable,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_control_ran,
    output logic [3:0]         o_new_mode,
    output logic               o_mode_changed,
    output logic [1:0]         o_charge_drive,
    output logic [2:0]         o_stop_reason,
    output logic               o_discharge_off,
    output logic               o_reload_counter,
    output logic [30:0]        o_reload_value,
    output logic               o_save_capacity,
    output logic [30:0]        o_saved_capacity_value,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic              r_in_valid;
    bctc_pkg::t_item   r_item;
    logic              r_out_valid;
    bctc_pkg::t_result r_result;
    bctc_pkg::t_state  r_state;
    bctc_pkg::t_cfg    r_cfg;
    bctc_pkg::t_state  n_state;
    bctc_pkg::t_result n_result;
    logic              advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_time  <= 16'd10;
            r_cfg.off_time <= 16'd60;
            r_cfg.tmax     <= 16'sd450;
            r_cfg.v_floor  <= 16'd1300;
            r_cfg.vmax     <= 16'd1800;
            r_cfg.rise     <= 16'd3;
            r_cfg.drop     <= 16'd10;
            r_cfg.cutoff   <= 16'd1000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bctc_pkg::REG_ON_TIME:  r_cfg.on_time  <= i_cfg_data;
                bctc_pkg::REG_OFF_TIME: r_cfg.off_time <= i_cfg_data;
                bctc_pkg::REG_TMAX:     r_cfg.tmax     <= $signed(i_cfg_data);
                bctc_pkg::REG_FLOOR:    r_cfg.v_floor  <= i_cfg_data;
                bctc_pkg::REG_VMAX:     r_cfg.vmax     <= i_cfg_data;
                bctc_pkg::REG_RISE:     r_cfg.rise     <= i_cfg_data;
                bctc_pkg::REG_DROP:     r_cfg.drop     <= i_cfg_data;
                bctc_pkg::REG_CUTOFF:   r_cfg.cutoff   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.opcode          <= i_opcode;
            r_item.now_seconds     <= i_now_seconds;
            r_item.battery_mode    <= i_battery_mode;
            r_item.cell_voltage    <= i_cell_voltage;
            r_item.temp_oldest     <= i_temp_oldest;
            r_item.temp_middle     <= i_temp_middle;
            r_item.temp_newest     <= i_temp_newest;
            r_item.charge_pumped   <= i_charge_pumped;
            r_item.stored_capacity <= i_stored_capacity;
            r_item.discharge_meter <= i_discharge_meter;
            r_item.trickle_enable  <= i_trickle_enable;
        end
    end

    bctc_rules u_rules (
        .i_item   (r_item),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Commit state as the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_control_time   <= '0;
            r_state.trickle_active      <= 1'b0;
            r_state.trickle_phase_start <= '0;
            r_state.voltage_peak        <= '0;
            r_state.capacity_limit      <= bctc_pkg::CAP_LIMIT_RST;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_control_ran          = r_result.control_ran;
    assign o_new_mode             = r_result.new_mode;
    assign o_mode_changed         = r_result.mode_changed;
    assign o_charge_drive         = r_result.charge_drive;
    assign o_stop_reason          = r_result.stop_reason;
    assign o_discharge_off        = r_result.discharge_off;
    assign o_reload_counter       = r_result.reload_counter;
    assign o_reload_value         = r_result.reload_value;
    assign o_save_capacity        = r_result.save_capacity;
    assign o_saved_capacity_value = r_result.saved_capacity_value;

endmodule

// File: hdl/bctc_checker.sv
// ----------------------------------------------------------------------------
// Charge termination control checker
// Port-level checks on results, bound to the top level.
// ----------------------------------------------------------------------------
`include "battery_charge_termination_control_top_defines.svh"

module bctc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_control_ran,
    input logic [3:0]  o_new_mode,
    input logic        o_mode_changed,
    input logic [1:0]  o_charge_drive,
    input logic [2:0]  o_stop_reason,
    input logic        o_discharge_off,
    input logic        o_reload_counter,
    input logic [30:0] o_reload_value,
    input logic        o_save_capacity
);

    // A stalled result holds until its transfer
    `BCTC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_new_mode) && $stable(o_stop_reason), "result dropped or changed while stalled")

    // Without a control run nothing may act
    `BCTC_ASSERT_OUT(a_idle_quiet, i_clk, i_rst_n, o_out_valid && !o_control_ran, !o_mode_changed && o_charge_drive == bctc_pkg::DRIVE_NONE && o_stop_reason == bctc_pkg::STOP_NONE && !o_discharge_off && !o_reload_counter && !o_save_capacity, "action without control run")

    // A charge stop switches off, reloads and changes mode
    `BCTC_ASSERT_OUT(a_stop_actions, i_clk, i_rst_n, o_out_valid && o_stop_reason != bctc_pkg::STOP_NONE, o_reload_counter && o_mode_changed && o_charge_drive == bctc_pkg::DRIVE_OFF, "charge stop without its actions")

    // Capacity is saved only at the end of the CTC discharge
    `BCTC_ASSERT_OUT(a_save_mode, i_clk, i_rst_n, o_out_valid && o_save_capacity, o_discharge_off && o_new_mode == bctc_pkg::MODE_CTC_DISCHARGED && o_reload_value == 31'd0, "capacity save outside discharge end")

endmodule

bind battery_charge_termination_control_top bctc_checker u_bctc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_control_ran    (o_control_ran),
    .o_new_mode       (o_new_mode),
    .o_mode_changed   (o_mode_changed),
    .o_charge_drive   (o_charge_drive),
    .o_stop_reason    (o_stop_reason),
    .o_discharge_off  (o_discharge_off),
    .o_reload_counter (o_reload_counter),
    .o_reload_value   (o_reload_value),
    .o_save_capacity  (o_save_capacity)
);
